@@ rtl/core/rifx_pkg.sv @@
// Package for the replay identifier filter: table sizing, verdict codes,
// store request and compare result types. No dependencies.

package rifx_pkg;

  localparam int unsigned TableDepth = 64;
  localparam int unsigned PtrW       = $clog2(TableDepth);
  localparam int unsigned CntW       = $clog2(TableDepth + 1);
  localparam int unsigned IdW        = 64;
  localparam int unsigned TimeW      = 64;
  localparam int unsigned LifeW      = 32;

  localparam logic [LifeW-1:0] LifetimeReset = LifeW'(60 * 1000 * 1000);

  typedef enum logic [1:0] {
    VerdictFresh  = 2'd0,
    VerdictReplay = 2'd1,
    VerdictFull   = 2'd2
  } verdict_e;

  typedef struct packed {
    logic [PtrW-1:0]  rd_addr;
    logic             wr_en;
    logic [PtrW-1:0]  wr_addr;
    logic [IdW-1:0]   wr_id;
    logic [TimeW-1:0] wr_expiry;
    logic             clr_en;
    logic [PtrW-1:0]  clr_addr;
  } store_req_t;

  typedef struct packed {
    logic [IdW-1:0]   rd_id;
    logic [TimeW-1:0] rd_expiry;
    logic             rd_valid;
  } store_rsp_t;

  typedef struct packed {
    logic lt;
    logic eq;
  } cmp_res_t;

  function automatic logic [PtrW-1:0] next_slot(input logic [PtrW-1:0] p);
    logic [PtrW-1:0] r;
    if (p == PtrW'(TableDepth - 1)) begin
      r = '0;
    end else begin
      r = p + PtrW'(1);
    end
    return r;
  endfunction

endpackage

@@ rtl/core/rifx_if.sv @@
// Request and response channel interfaces of the replay identifier filter.
// Depends on rifx_pkg.

interface rifx_req_if;
  logic                          valid;
  logic                          ready;
  logic [rifx_pkg::IdW-1:0]      identifier;
  logic [rifx_pkg::TimeW-1:0]    now_us;

  modport source (output valid, output identifier, output now_us, input ready);
  modport sink   (input valid, input identifier, input now_us, output ready);
endinterface

interface rifx_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] verdict;

  modport source (output valid, output verdict, input ready);
  modport sink   (input valid, input verdict, output ready);
endinterface

@@ rtl/core/rifx_cmp.sv @@
// Shared 64-bit compare unit used by the eviction walk and the lookup scan.
// Depends on rifx_pkg.

module rifx_cmp (
  input  logic [rifx_pkg::TimeW-1:0] op_a_i,
  input  logic [rifx_pkg::TimeW-1:0] op_b_i,
  output rifx_pkg::cmp_res_t         res_o
);

  always_comb begin
    res_o.lt = (op_a_i < op_b_i);
    res_o.eq = (op_a_i == op_b_i);
  end

endmodule

@@ rtl/core/rifx_store.sv @@
// Slot store: identifier and expiry memories with one registered read port,
// one write port and per-slot valid flops. Depends on rifx_pkg.

module rifx_store (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  rifx_pkg::store_req_t req_i,
  output rifx_pkg::store_rsp_t rsp_o
);

  logic [rifx_pkg::IdW-1:0]      id_mem     [rifx_pkg::TableDepth];
  logic [rifx_pkg::TimeW-1:0]    expiry_mem [rifx_pkg::TableDepth];
  logic [rifx_pkg::TableDepth-1:0] valid_q;
  logic [rifx_pkg::IdW-1:0]      rd_id_q;
  logic [rifx_pkg::TimeW-1:0]    rd_expiry_q;
  logic                          rd_valid_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      id_mem[req_i.wr_addr]     <= req_i.wr_id;
      expiry_mem[req_i.wr_addr] <= req_i.wr_expiry;
    end
    rd_id_q     <= id_mem[req_i.rd_addr];
    rd_expiry_q <= expiry_mem[req_i.rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      rd_valid_q <= valid_q[req_i.rd_addr];
      if (req_i.wr_en) begin
        valid_q[req_i.wr_addr] <= 1'b1;
      end
      if (req_i.clr_en) begin
        valid_q[req_i.clr_addr] <= 1'b0;
      end
    end
  end

  assign rsp_o.rd_id     = rd_id_q;
  assign rsp_o.rd_expiry = rd_expiry_q;
  assign rsp_o.rd_valid  = rd_valid_q;

endmodule

@@ rtl/core/replay_id_filter_with_expiry_unit.sv @@
// Top level of the replay identifier filter with expiry: sequencer, pointers,
// lifetime register and response register. Depends on rifx_pkg, rifx_if,
// rifx_cmp and rifx_store.
//
//  channel | dir | handshake     | payload
//  req     | in  | valid/ready   | identifier[63:0], now_us[63:0]
//  rsp     | out | valid/ready   | verdict[1:0]
//  cfg     | in  | cfg_we_i      | cfg_wdata_i[31:0] (lifetime_us)
//
// After a request is accepted, the eviction walk frees the expired entries at
// the head of the table and a scan over the slot memory read port looks for
// the identifier; the verdict then shows on rsp.
// Reset leaves an empty table and lifetime_us at 60000000.
// req.ready is high only while the sequencer is idle; a response waiting on
// rsp.ready holds the next result back but not the next request.

module replay_id_filter_with_expiry_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  rifx_req_if.sink                        req,
  rifx_rsp_if.source                      rsp,
  input  logic                            cfg_we_i,
  input  logic [rifx_pkg::LifeW-1:0]      cfg_wdata_i
);

  typedef enum logic [5:0] {
    StIdle   = 6'b000001,
    StEvRd   = 6'b000010,
    StEvCmp  = 6'b000100,
    StScan   = 6'b001000,
    StDecide = 6'b010000,
    StDone   = 6'b100000
  } state_e;

  state_e                         state_q, state_d;
  logic [rifx_pkg::IdW-1:0]       id_q, id_d;
  logic [rifx_pkg::TimeW-1:0]     now_q, now_d;
  logic [rifx_pkg::LifeW-1:0]     life_q, life_d;
  logic [rifx_pkg::PtrW-1:0]      head_q, head_d, tail_q, tail_d;
  logic [rifx_pkg::CntW-1:0]      live_q, live_d, cnt_q, cnt_d;
  logic                           hit_q, hit_d;
  rifx_pkg::verdict_e             verdict_q, verdict_d, out_verdict_q, out_verdict_d;
  logic                           out_valid_q, out_valid_d;

  rifx_pkg::store_req_t           st_req;
  rifx_pkg::store_rsp_t           st_rsp;
  logic [rifx_pkg::TimeW-1:0]     cmp_a, cmp_b;
  rifx_pkg::cmp_res_t             cmp_res;
  logic [rifx_pkg::TimeW:0]       exp_sum;
  logic [rifx_pkg::TimeW-1:0]     exp_sat;

  rifx_store u_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (st_req),
    .rsp_o  (st_rsp)
  );

  rifx_cmp u_cmp (
    .op_a_i (cmp_a),
    .op_b_i (cmp_b),
    .res_o  (cmp_res)
  );

  assign req.ready   = (state_q == StIdle);
  assign rsp.valid   = out_valid_q;
  assign rsp.verdict = out_verdict_q;

  assign exp_sum = {1'b0, now_q} + {{(rifx_pkg::TimeW + 1 - rifx_pkg::LifeW){1'b0}}, life_q};
  assign exp_sat = exp_sum[rifx_pkg::TimeW] ? '1 : exp_sum[rifx_pkg::TimeW-1:0];

  always_comb begin
    state_d       = state_q;
    id_d          = id_q;
    now_d         = now_q;
    life_d        = cfg_we_i ? cfg_wdata_i : life_q;
    head_d        = head_q;
    tail_d        = tail_q;
    live_d        = live_q;
    cnt_d         = cnt_q;
    hit_d         = hit_q;
    verdict_d     = verdict_q;
    out_valid_d   = out_valid_q && !rsp.ready;
    out_verdict_d = out_verdict_q;

    st_req           = '0;
    st_req.rd_addr   = head_q;
    st_req.wr_addr   = tail_q;
    st_req.wr_id     = id_q;
    st_req.wr_expiry = exp_sat;
    st_req.clr_addr  = head_q;

    cmp_a = st_rsp.rd_expiry;
    cmp_b = now_q;

    unique case (state_q)
      StIdle: begin
        if (req.valid) begin
          id_d    = req.identifier;
          now_d   = req.now_us;
          state_d = StEvRd;
        end
      end
      StEvRd: begin
        if (live_q == '0) begin
          cnt_d   = '0;
          hit_d   = 1'b0;
          state_d = StScan;
        end else begin
          state_d = StEvCmp;
        end
      end
      StEvCmp: begin
        if (st_rsp.rd_valid && cmp_res.lt) begin
          st_req.clr_en = 1'b1;
          head_d        = rifx_pkg::next_slot(head_q);
          live_d        = live_q - rifx_pkg::CntW'(1);
          state_d       = StEvRd;
        end else begin
          cnt_d   = '0;
          hit_d   = 1'b0;
          state_d = StScan;
        end
      end
      StScan: begin
        cmp_a = st_rsp.rd_id;
        cmp_b = id_q;
        st_req.rd_addr = (cnt_q == rifx_pkg::CntW'(rifx_pkg::TableDepth)) ?
                         '0 : cnt_q[rifx_pkg::PtrW-1:0];
        if (cnt_q != '0) begin
          hit_d = hit_q || (st_rsp.rd_valid && cmp_res.eq);
        end
        if (cnt_q == rifx_pkg::CntW'(rifx_pkg::TableDepth)) begin
          state_d = StDecide;
        end else begin
          cnt_d = cnt_q + rifx_pkg::CntW'(1);
        end
      end
      StDecide: begin
        if (hit_q) begin
          verdict_d = rifx_pkg::VerdictReplay;
        end else if (live_q == rifx_pkg::CntW'(rifx_pkg::TableDepth)) begin
          verdict_d = rifx_pkg::VerdictFull;
        end else begin
          st_req.wr_en = 1'b1;
          tail_d       = rifx_pkg::next_slot(tail_q);
          live_d       = live_q + rifx_pkg::CntW'(1);
          verdict_d    = rifx_pkg::VerdictFresh;
        end
        state_d = StDone;
      end
      StDone: begin
        if (!out_valid_q || rsp.ready) begin
          out_valid_d   = 1'b1;
          out_verdict_d = verdict_q;
          state_d       = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      life_q      <= rifx_pkg::LifetimeReset;
      head_q      <= '0;
      tail_q      <= '0;
      live_q      <= '0;
      cnt_q       <= '0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      life_q      <= life_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      live_q      <= live_d;
      cnt_q       <= cnt_d;
      hit_q       <= hit_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q          <= id_d;
    now_q         <= now_d;
    verdict_q     <= verdict_d;
    out_verdict_q <= out_verdict_d;
  end

endmodule

@@ rtl/core/rifx_checker.sv @@
// Port-level checks for the replay identifier filter and their bind.
// Depends on replay_id_filter_with_expiry_unit and rifx_pkg.

module rifx_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       req_valid_i,
  input logic       req_ready_i,
  input logic       rsp_valid_i,
  input logic       rsp_ready_i,
  input logic [1:0] rsp_verdict_i
);

  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request accepted while a request is in flight");

  a_busy_two_cycles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> ##1 !req_ready_i)
    else $error("request finished too early");

  a_verdict_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> (rsp_verdict_i == rifx_pkg::VerdictFresh ||
                     rsp_verdict_i == rifx_pkg::VerdictReplay ||
                     rsp_verdict_i == rifx_pkg::VerdictFull))
    else $error("illegal verdict code");

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_verdict_i))
    else $error("stalled response changed");

endmodule

bind replay_id_filter_with_expiry_unit rifx_checker u_rifx_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .req_valid_i   (req.valid),
  .req_ready_i   (req.ready),
  .rsp_valid_i   (rsp.valid),
  .rsp_ready_i   (rsp.ready),
  .rsp_verdict_i (rsp.verdict)
);

@@ bench/rifx_tb_pkg.sv @@
// Verdict tracker for the replay identifier filter bench: keeps its own copy of
// the insertion-ordered slot ring and checks each response against the queue.
// Depends on rifx_pkg.

package rifx_tb_pkg;

  import rifx_pkg::*;

  class replay_verdict_tracker;
    logic [IdW-1:0]   slot_key[TableDepth];
    logic [TimeW-1:0] slot_deadline[TableDepth];
    bit               slot_live[TableDepth];
    int unsigned      oldest;
    int unsigned      next_free;
    int unsigned      occupancy;
    logic [LifeW-1:0] lifetime;
    verdict_e         verdict_due[$];
    int unsigned      failures;
    int unsigned      responses;

    function new();
      for (int i = 0; i < TableDepth; i++) begin
        slot_key[i]      = '0;
        slot_deadline[i] = '0;
        slot_live[i]     = 1'b0;
      end
      oldest    = 0;
      next_free = 0;
      occupancy = 0;
      lifetime  = LifetimeReset;
      failures  = 0;
      responses = 0;
    endfunction

    function void set_lifetime(input logic [LifeW-1:0] value);
      lifetime = value;
    endfunction

    function int unsigned pending();
      return verdict_due.size();
    endfunction

    function void note_request(input logic [IdW-1:0] id, input logic [TimeW-1:0] now);
      logic [TimeW:0] sum;
      bit             hit;
      verdict_e       v;
      // drop expired entries from the head, stop at the first one not expired
      while (occupancy > 0 && slot_live[oldest] && slot_deadline[oldest] < now) begin
        slot_live[oldest] = 1'b0;
        oldest = (oldest + 1) % TableDepth;
        occupancy--;
      end
      hit = 1'b0;
      for (int i = 0; i < TableDepth; i++) begin
        if (slot_live[i] && slot_key[i] == id) hit = 1'b1;
      end
      if (hit) begin
        v = VerdictReplay;
      end else if (occupancy >= TableDepth) begin
        v = VerdictFull;
      end else begin
        sum = {1'b0, now} + (TimeW+1)'(lifetime);
        slot_key[next_free]      = id;
        slot_deadline[next_free] = sum[TimeW] ? '1 : sum[TimeW-1:0];
        slot_live[next_free]     = 1'b1;
        next_free = (next_free + 1) % TableDepth;
        occupancy++;
        v = VerdictFresh;
      end
      verdict_due.push_back(v);
    endfunction

    function void check_verdict(input logic [1:0] got);
      verdict_e want;
      responses++;
      if (verdict_due.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("response %0d: verdict %0d with no request outstanding", responses, got);
      end else begin
        want = verdict_due.pop_front();
        if (got !== want) begin
          failures++;
          if (failures <= 10)
            $display("response %0d: verdict expected %0d (%s), got %0d",
                     responses, want, want.name(), got);
        end
      end
    endfunction
  endclass

endpackage

@@ bench/tb_top.sv @@
// Top of the replay identifier filter bench: clock, reset, request and
// response drivers, lifetime phases. Depends on rifx_pkg, rifx_if,
// rifx_tb_pkg and replay_id_filter_with_expiry_unit.

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rifx_pkg::*;
  import rifx_tb_pkg::*;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             cfg_we;
  logic [LifeW-1:0] cfg_wdata;

  rifx_req_if req_ch();
  rifx_rsp_if rsp_ch();

  replay_id_filter_with_expiry_unit dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .req        (req_ch),
    .rsp        (rsp_ch),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata)
  );

  always #6 clk = ~clk;

  replay_verdict_tracker tracker = new();

  logic [IdW-1:0] recent_ids[$];
  int unsigned    burst_left = 0;
  int unsigned    requests_sent = 0;
  bit             hold_off_due = 1'b0;

  function automatic logic [TimeW-1:0] later(input logic [TimeW-1:0] t,
                                             input logic [TimeW-1:0] delta);
    logic [TimeW-1:0] s;
    s = t + delta;
    return (s < t) ? '1 : s;
  endfunction

  function automatic logic [IdW-1:0] pick_id();
    int unsigned r;
    int unsigned n;
    r = $urandom_range(0, 99);
    n = recent_ids.size();
    if (r < 35 && n > 0) return recent_ids[$urandom_range(0, n - 1)];
    if (r < 42 && n > 0) return recent_ids[$urandom_range(0, n - 1)] ^ (64'd1 << $urandom_range(0, 63));
    if (r < 44) return 64'($urandom_range(0, 3));
    if (r < 46) return ~64'($urandom_range(0, 3));
    return {$urandom, $urandom};
  endfunction

  // offer one request, hold it until accepted, then continue the burst or idle
  task automatic offer(input logic [IdW-1:0] id, input logic [TimeW-1:0] now);
    req_ch.identifier <= id;
    req_ch.now_us     <= now;
    req_ch.valid      <= 1'b1;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    tracker.note_request(id, now);
    recent_ids.push_back(id);
    if (recent_ids.size() > 96) void'(recent_ids.pop_front());
    requests_sent++;
    if (requests_sent == 60) hold_off_due = 1'b1;
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      int unsigned r;
      int unsigned gap;
      req_ch.valid <= 1'b0;
      r = $urandom_range(0, 99);
      gap = (r < 50) ? $urandom_range(1, 5) : (r < 80) ? $urandom_range(6, 40) :
            $urandom_range(41, 120);
      repeat (gap) @(negedge clk);
      burst_left = $urandom_range(0, 30);
    end
  endtask

  task automatic drain();
    req_ch.valid <= 1'b0;
    while (tracker.pending() != 0) @(negedge clk);
  endtask

  task automatic write_lifetime(input logic [LifeW-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    tracker.set_lifetime(value);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // response side: random stall patterns plus one long hold-off
  initial begin
    int unsigned mode;
    int unsigned mode_left;
    int unsigned hold_left;
    int unsigned tick;
    mode      = 0;
    mode_left = 0;
    hold_left = 0;
    tick      = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && rsp_ch.valid && rsp_ch.ready) tracker.check_verdict(rsp_ch.verdict);
      @(negedge clk);
      tick++;
      if (hold_off_due) begin
        hold_off_due = 1'b0;
        hold_left = 3000;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(0, 3);
          mode_left = $urandom_range(20, 200);
        end
        mode_left--;
        case (mode)
          0: rsp_ch.ready <= 1'b1;
          1: rsp_ch.ready <= ($urandom_range(0, 1) == 1);
          2: rsp_ch.ready <= ($urandom_range(0, 99) < 85);
          default: rsp_ch.ready <= (tick % 4 == 0);
        endcase
      end
    end
  end

  initial begin
    logic [LifeW-1:0] life;
    logic [TimeW-1:0] clock_us;
    logic [TimeW-1:0] base;
    logic [IdW-1:0]   probe;
    int unsigned      pace;
    int unsigned      r;
    int unsigned      back;
    req_ch.valid      = 1'b0;
    req_ch.identifier = '0;
    req_ch.now_us     = '0;
    cfg_we            = 1'b0;
    cfg_wdata         = '0;
    rst_n             = 1'b0;
    life              = LifetimeReset;
    pace              = 1;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int ph = 0; ph < 8; ph++) begin
      if (ph > 0) begin
        case (ph)
          1: life = 32'd1;
          2: life = 32'd0;
          3: life = 32'hFFFF_FFFF;
          4: life = $urandom;
          5: life = $urandom_range(16, 65535);
          6: life = LifetimeReset;
          default: life = 32'hFFFF_FFFF;
        endcase
        drain();
        write_lifetime(life);
      end
      base = {$urandom, $urandom};
      base[63:61] = 3'(ph);
      if (ph == 0) base = '0;
      if (ph == 7) base = 64'hFFFF_FFFC_0000_0000 + 64'($urandom);
      clock_us = base;

      case (ph)
        0: begin
          offer(64'd0, 64'd0);
          offer(64'd0, 64'd0);
          offer('1, 64'd5);
          offer(64'h8000_0000_0000_0000, 64'd10);
          offer(64'd1, 64'd10);
          offer(64'd0, 64'd60_000_000);
          offer(64'd0, 64'd3);
          offer(64'd0, 64'd60_000_001);
          offer('1, 64'd60_000_001);
          clock_us = 64'd60_000_001;
        end
        1, 2: begin
          probe = {$urandom, $urandom};
          offer(probe, clock_us);
          offer(probe, clock_us + 64'(life));
          offer(probe, clock_us + 64'(life) + 64'd1);
          clock_us = clock_us + 64'(life) + 64'd1;
        end
        default: ;
      endcase

      for (int n = 0; n < 200; n++) begin
        if (n % 40 == 0) begin
          case ($urandom_range(0, 2))
            0: pace = (life >> 2) + 1;
            1: pace = (life >> 5) + 1;
            default: pace = (life >> 8) + 1;
          endcase
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
          back = $urandom_range(0, pace);
          if (clock_us >= 64'(back)) clock_us = clock_us - 64'(back);
        end else if (r < 5) begin
          clock_us = later(clock_us, 64'(life) + 64'(pace) + 64'd1);
        end else begin
          clock_us = later(clock_us, 64'($urandom_range(0, pace)));
        end
        offer(pick_id(), clock_us);
      end
    end

    // time pinned at its maximum: expiry saturates
    probe = {$urandom, $urandom};
    offer(probe, '1);
    offer(probe, '1);
    offer(recent_ids[0], '1);
    drain();
    repeat (250) @(posedge clk);
    if (tracker.failures == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #48_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

@@ replay_id_filter_with_expiry_unit.f @@
rtl/core/rifx_pkg.sv
rtl/core/rifx_if.sv
rtl/core/rifx_cmp.sv
rtl/core/rifx_store.sv
rtl/core/replay_id_filter_with_expiry_unit.sv
rtl/core/rifx_checker.sv
bench/rifx_tb_pkg.sv
bench/tb_top.sv
